FILE: rtl/eta_pkg.sv
// eta_pkg: shared types, widths and constants for the encoder tuning accelerator
// used by eta_cfg, eta_step, eta_upd and the top level
package eta_pkg;

  localparam int BASE_W  = 20;
  localparam int FREQ_W  = 32;
  localparam int WIN_W   = 20;
  localparam int DELTA_W = 16;
  localparam int MAG_W   = 16;
  localparam int MULT_W  = 10;
  localparam int CNT_W   = 32;
  localparam int BM_W    = BASE_W + MULT_W;
  localparam int STEP_W  = DELTA_W + BM_W + 1;
  localparam int SUM_W   = STEP_W + 1;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;

  typedef enum logic [1:0] {
    REG_BASE_STEP  = 2'd0,
    REG_BAND_LOW   = 2'd1,
    REG_BAND_HIGH  = 2'd2,
    REG_REV_WINDOW = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd2
  } dir_t;

  typedef enum logic {
    ACT_POLL   = 1'b0,
    ACT_INJECT = 1'b1
  } action_t;

  localparam logic [MULT_W-1:0] MULT_X1    = 10'd1;
  localparam logic [MULT_W-1:0] MULT_X10   = 10'd10;
  localparam logic [MULT_W-1:0] MULT_X100  = 10'd100;
  localparam logic [MULT_W-1:0] MULT_X1000 = 10'd1000;
  localparam logic [MULT_W-1:0] MULT_NONE  = 10'd0;

  localparam logic [MAG_W-1:0] MAG_LIM_X1  = 16'd1;
  localparam logic [MAG_W-1:0] MAG_LIM_X10 = 16'd5;
  localparam logic [MAG_W-1:0] MAG_LIM_X100 = 16'd15;

  localparam logic [BASE_W-1:0] BASE_STEP_RST  = 20'd1;
  localparam logic [FREQ_W-1:0] BAND_LOW_RST   = 32'h0000_0000;
  localparam logic [FREQ_W-1:0] BAND_HIGH_RST  = 32'hFFFF_FFFF;
  localparam logic [WIN_W-1:0]  REV_WINDOW_RST = 20'd20000;

  typedef struct packed {
    logic [BASE_W-1:0] step_unit_hz;
    logic [FREQ_W-1:0] band_low_hz;
    logic [FREQ_W-1:0] band_high_hz;
    logic [WIN_W-1:0]  reversal_window_us;
  } cfg_t;

  typedef struct packed {
    logic                      action;
    logic signed [DELTA_W-1:0] delta;
    logic [MAG_W-1:0]          mag;
    logic [MULT_W-1:0]         mult;
    logic [FREQ_W-1:0]         present;
    logic [BM_W-1:0]           bm;
  } s2_t;

  typedef struct packed {
    logic                     action;
    logic                     delta_zero;
    logic                     delta_neg;
    logic [MAG_W-1:0]         mag;
    logic [MULT_W-1:0]        mult;
    logic [FREQ_W-1:0]        present;
    logic signed [STEP_W-1:0] step;
  } s3_t;

  function automatic logic [MULT_W-1:0] pick_mult(input logic [MAG_W-1:0] mag);
    logic [MULT_W-1:0] m;
    if (mag <= MAG_LIM_X1) begin
      m = MULT_X1;
    end else if (mag <= MAG_LIM_X10) begin
      m = MULT_X10;
    end else if (mag <= MAG_LIM_X100) begin
      m = MULT_X100;
    end else begin
      m = MULT_X1000;
    end
    return m;
  endfunction

endpackage

FILE: rtl/eta_cfg.sv
// eta_cfg: apb register bank for step size, clamp band and reversal window
// depends on eta_pkg
module eta_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [eta_pkg::ADDR_W-1:0]    paddr,
  input  logic [eta_pkg::DATA_W-1:0]    pwdata,
  output logic [eta_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output eta_pkg::cfg_t                 cfg
);
  import eta_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_BASE_STEP:  cfg_nxt.step_unit_hz       = pwdata[BASE_W-1:0];
        REG_BAND_LOW:   cfg_nxt.band_low_hz        = pwdata[FREQ_W-1:0];
        REG_BAND_HIGH:  cfg_nxt.band_high_hz       = pwdata[FREQ_W-1:0];
        REG_REV_WINDOW: cfg_nxt.reversal_window_us = pwdata[WIN_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BASE_STEP:  prdata = DATA_W'(cfg_r.step_unit_hz);
      REG_BAND_LOW:   prdata = DATA_W'(cfg_r.band_low_hz);
      REG_BAND_HIGH:  prdata = DATA_W'(cfg_r.band_high_hz);
      REG_REV_WINDOW: prdata = DATA_W'(cfg_r.reversal_window_us);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_unit_hz       <= BASE_STEP_RST;
      cfg_r.band_low_hz        <= BAND_LOW_RST;
      cfg_r.band_high_hz       <= BAND_HIGH_RST;
      cfg_r.reversal_window_us <= REV_WINDOW_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/eta_step.sv
// eta_step: input register, multiplier selection and step product pipeline
// depends on eta_pkg; feeds eta_upd
module eta_step #(
  parameter int TIME_BITS = 48
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_action,
  input  logic signed [eta_pkg::DELTA_W-1:0] in_count_delta,
  input  logic [TIME_BITS-1:0]               in_time_us,
  input  logic [eta_pkg::FREQ_W-1:0]         in_present_freq_hz,
  input  logic [eta_pkg::BASE_W-1:0]         step_unit_hz,
  output logic                               s3_valid,
  input  logic                               s3_ready,
  output eta_pkg::s3_t                       s3,
  output logic [TIME_BITS-1:0]               s3_time
);
  import eta_pkg::*;

  logic                      v1_r;
  logic                      act1_r;
  logic signed [DELTA_W-1:0] dlt1_r;
  logic [TIME_BITS-1:0]      time1_r;
  logic [FREQ_W-1:0]         pres1_r;

  logic                 v2_r;
  s2_t                  s2_r;
  s2_t                  s2_nxt;
  logic [TIME_BITS-1:0] time2_r;

  logic                 v3_r;
  s3_t                  s3_r;
  s3_t                  s3_nxt;
  logic [TIME_BITS-1:0] time3_r;

  logic             rdy1;
  logic             rdy2;
  logic             rdy3;
  logic [MAG_W-1:0] mag1;
  logic [MULT_W-1:0] mult1;

  assign rdy3     = !v3_r || s3_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign mag1  = dlt1_r[DELTA_W-1] ? (MAG_W'(~dlt1_r) + MAG_W'(1)) : MAG_W'(dlt1_r);
  assign mult1 = pick_mult(mag1);

  always_comb begin
    s2_nxt.action  = act1_r;
    s2_nxt.delta   = dlt1_r;
    s2_nxt.mag     = mag1;
    s2_nxt.mult    = mult1;
    s2_nxt.present = pres1_r;
    s2_nxt.bm      = BM_W'(step_unit_hz) * BM_W'(mult1);
  end

  always_comb begin
    s3_nxt.action     = s2_r.action;
    s3_nxt.delta_zero = (s2_r.delta == '0);
    s3_nxt.delta_neg  = s2_r.delta[DELTA_W-1];
    s3_nxt.mag        = s2_r.mag;
    s3_nxt.mult       = s2_r.mult;
    s3_nxt.present    = s2_r.present;
    s3_nxt.step       = STEP_W'($signed(s2_r.delta)) * STEP_W'($signed({1'b0, s2_r.bm}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      act1_r  <= in_action;
      dlt1_r  <= in_count_delta;
      time1_r <= in_time_us;
      pres1_r <= in_present_freq_hz;
    end
    if (rdy2) begin
      s2_r    <= s2_nxt;
      time2_r <= time1_r;
    end
    if (rdy3) begin
      s3_r    <= s3_nxt;
      time3_r <= time2_r;
    end
  end

  assign s3_valid = v3_r;
  assign s3       = s3_r;
  assign s3_time  = time3_r;

endmodule

FILE: rtl/eta_upd.sv
// eta_upd: debounce decision, band clamp, poll statistics and result register
// depends on eta_pkg; fed by eta_step
module eta_upd #(
  parameter int TIME_BITS = 48
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  eta_pkg::cfg_t                cfg,
  input  logic                         s3_valid,
  output logic                         s3_ready,
  input  eta_pkg::s3_t                 s3,
  input  logic [TIME_BITS-1:0]         s3_time,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [eta_pkg::FREQ_W-1:0]   out_next_freq_hz,
  output logic                         out_freq_changed,
  output logic                         out_was_suppressed,
  output logic [eta_pkg::MULT_W-1:0]   out_applied_multiplier,
  output logic [eta_pkg::CNT_W-1:0]    out_poll_total,
  output logic [eta_pkg::CNT_W-1:0]    out_abs_ticks_total,
  output logic [eta_pkg::MAG_W-1:0]    out_recent_abs_delta,
  output logic [eta_pkg::MULT_W-1:0]   out_recent_multiplier
);
  import eta_pkg::*;

  dir_t                 prev_dir_r;
  dir_t                 prev_dir_nxt;
  logic [TIME_BITS-1:0] prev_time_r;
  logic [TIME_BITS-1:0] prev_time_nxt;
  logic [CNT_W-1:0]     poll_cnt_r;
  logic [CNT_W-1:0]     poll_cnt_nxt;
  logic [CNT_W-1:0]     abs_sum_r;
  logic [CNT_W-1:0]     abs_sum_nxt;
  logic [MAG_W-1:0]     last_mag_r;
  logic [MAG_W-1:0]     last_mag_nxt;
  logic [MULT_W-1:0]    last_mult_r;
  logic [MULT_W-1:0]    last_mult_nxt;

  logic              out_valid_r;
  logic [FREQ_W-1:0] next_freq_r;
  logic [FREQ_W-1:0] next_freq_nxt;
  logic              changed_r;
  logic              supp_r;
  logic              supp_nxt;
  logic [MULT_W-1:0] mult_r;
  logic [MULT_W-1:0] mult_nxt;

  logic                    fire;
  logic                    polled;
  logic                    apply;
  dir_t                    dir;
  logic [TIME_BITS-1:0]    elapsed;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] lo_s;
  logic signed [SUM_W-1:0] hi_s;
  logic signed [SUM_W-1:0] floor_v;
  logic signed [SUM_W-1:0] clamp_v;

  assign s3_ready = !out_valid_r || out_ready;
  assign fire     = s3_valid && s3_ready;
  assign polled   = (s3.action == ACT_POLL);
  assign dir      = s3.delta_neg ? DIR_NEG : DIR_POS;
  assign elapsed  = s3_time - prev_time_r;

  assign sum     = $signed({{(SUM_W-FREQ_W){1'b0}}, s3.present}) + SUM_W'(s3.step);
  assign lo_s    = $signed({{(SUM_W-FREQ_W){1'b0}}, cfg.band_low_hz});
  assign hi_s    = $signed({{(SUM_W-FREQ_W){1'b0}}, cfg.band_high_hz});
  assign floor_v = (sum < lo_s) ? lo_s : sum;
  assign clamp_v = (floor_v > hi_s) ? hi_s : floor_v;

  always_comb begin
    supp_nxt = polled && !s3.delta_zero && (prev_dir_r != DIR_NONE) && (dir != prev_dir_r)
               && (elapsed < TIME_BITS'(cfg.reversal_window_us));
    apply         = !s3.delta_zero && !supp_nxt;
    next_freq_nxt = apply ? clamp_v[FREQ_W-1:0] : s3.present;
    mult_nxt      = apply ? s3.mult : MULT_NONE;

    prev_dir_nxt  = prev_dir_r;
    prev_time_nxt = prev_time_r;
    poll_cnt_nxt  = poll_cnt_r;
    abs_sum_nxt   = abs_sum_r;
    last_mag_nxt  = last_mag_r;
    last_mult_nxt = last_mult_r;
    if (polled) begin
      poll_cnt_nxt = poll_cnt_r + CNT_W'(1);
      abs_sum_nxt  = abs_sum_r + CNT_W'(s3.mag);
      last_mag_nxt = s3.mag;
      if (apply) begin
        prev_dir_nxt  = dir;
        prev_time_nxt = s3_time;
        last_mult_nxt = s3.mult;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_dir_r  <= DIR_NONE;
      prev_time_r <= '0;
      poll_cnt_r  <= '0;
      abs_sum_r   <= '0;
      last_mag_r  <= '0;
      last_mult_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        prev_dir_r  <= prev_dir_nxt;
        prev_time_r <= prev_time_nxt;
        poll_cnt_r  <= poll_cnt_nxt;
        abs_sum_r   <= abs_sum_nxt;
        last_mag_r  <= last_mag_nxt;
        last_mult_r <= last_mult_nxt;
      end
      if (s3_ready) begin
        out_valid_r <= s3_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      next_freq_r <= next_freq_nxt;
      changed_r   <= (next_freq_nxt != s3.present);
      supp_r      <= supp_nxt;
      mult_r      <= mult_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_next_freq_hz       = next_freq_r;
  assign out_freq_changed       = changed_r;
  assign out_was_suppressed     = supp_r;
  assign out_applied_multiplier = mult_r;
  assign out_poll_total         = poll_cnt_r;
  assign out_abs_ticks_total    = abs_sum_r;
  assign out_recent_abs_delta   = last_mag_r;
  assign out_recent_multiplier  = last_mult_r;

endmodule

FILE: rtl/encoder_tuning_accelerator_top.sv
// encoder tuning accelerator top: eta_cfg, eta_step and eta_upd, uses eta_pkg
// pipeline: a result passes the input register, the base-times-multiplier register,
//   the step product register, then the result register
// throughput: one item per cycle unless out_ready stalls; debounce and stats unpipelined
// reset: synchronous active-low rst_n clears the pipeline, history and counters and
//   loads the register defaults; items are taken right after reset
module encoder_tuning_accelerator_top #(
  parameter int TIME_BITS = 48
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [eta_pkg::ADDR_W-1:0]         paddr,
  input  logic [eta_pkg::DATA_W-1:0]         pwdata,
  output logic [eta_pkg::DATA_W-1:0]         prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_action,
  input  logic signed [eta_pkg::DELTA_W-1:0] in_count_delta,
  input  logic [TIME_BITS-1:0]               in_time_us,
  input  logic [eta_pkg::FREQ_W-1:0]         in_present_freq_hz,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [eta_pkg::FREQ_W-1:0]         out_next_freq_hz,
  output logic                               out_freq_changed,
  output logic                               out_was_suppressed,
  output logic [eta_pkg::MULT_W-1:0]         out_applied_multiplier,
  output logic [eta_pkg::CNT_W-1:0]          out_poll_total,
  output logic [eta_pkg::CNT_W-1:0]          out_abs_ticks_total,
  output logic [eta_pkg::MAG_W-1:0]          out_recent_abs_delta,
  output logic [eta_pkg::MULT_W-1:0]         out_recent_multiplier
);
  import eta_pkg::*;

  cfg_t                 cfg;
  logic                 s3_valid;
  logic                 s3_ready;
  s3_t                  s3;
  logic [TIME_BITS-1:0] s3_time;

  eta_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  eta_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_count_delta     (in_count_delta),
    .in_time_us         (in_time_us),
    .in_present_freq_hz (in_present_freq_hz),
    .step_unit_hz       (cfg.step_unit_hz),
    .s3_valid           (s3_valid),
    .s3_ready           (s3_ready),
    .s3                 (s3),
    .s3_time            (s3_time)
  );

  eta_upd #(
    .TIME_BITS (TIME_BITS)
  ) u_upd (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg                    (cfg),
    .s3_valid               (s3_valid),
    .s3_ready               (s3_ready),
    .s3                     (s3),
    .s3_time                (s3_time),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_next_freq_hz       (out_next_freq_hz),
    .out_freq_changed       (out_freq_changed),
    .out_was_suppressed     (out_was_suppressed),
    .out_applied_multiplier (out_applied_multiplier),
    .out_poll_total         (out_poll_total),
    .out_abs_ticks_total    (out_abs_ticks_total),
    .out_recent_abs_delta   (out_recent_abs_delta),
    .out_recent_multiplier  (out_recent_multiplier)
  );

`ifndef SYNTHESIS
  a_supp_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_was_suppressed |-> !out_freq_changed && out_applied_multiplier == MULT_NONE)
    else $error("suppressed reversal applied a step");

  a_no_mult_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_applied_multiplier == MULT_NONE |-> !out_freq_changed)
    else $error("frequency changed without a step");

  a_mult_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_applied_multiplier == MULT_NONE || out_applied_multiplier == MULT_X1 ||
      out_applied_multiplier == MULT_X10 || out_applied_multiplier == MULT_X100 ||
      out_applied_multiplier == MULT_X1000)
    else $error("illegal multiplier");

  a_in_band: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_applied_multiplier != MULT_NONE && cfg.band_low_hz <= cfg.band_high_hz
    |-> out_next_freq_hz >= cfg.band_low_hz && out_next_freq_hz <= cfg.band_high_hz)
    else $error("stepped frequency outside band");
`endif

endmodule
